// File: rtl/flwd_pkg.sv
// Shared types and constants for the feature list wire decoder.
// No dependencies; imported by every flwd_* module.
`timescale 1ns / 1ps
`default_nettype none

package flwd_pkg;

  localparam logic [7:0] TagBytesList = 8'h0A;
  localparam logic [7:0] TagFloatList = 8'h12;
  localparam logic [7:0] TagInt64List = 8'h1A;
  localparam logic [7:0] TagDelimited = 8'h0A;
  localparam logic [7:0] TagFixed32   = 8'h0D;
  localparam logic [7:0] TagVarint    = 8'h08;

  localparam logic [1:0] KindInvalid = 2'd0;
  localparam logic [1:0] KindBytes   = 2'd1;
  localparam logic [1:0] KindFloat   = 2'd2;
  localparam logic [1:0] KindInt64   = 2'd3;

  localparam logic [1:0] StatusOk          = 2'd0;
  localparam logic [1:0] StatusUnsupported = 2'd1;
  localparam logic [1:0] StatusParseError  = 2'd2;

  localparam logic [3:0] VarintMaxBytes = 4'd10;
  localparam logic [1:0] WordLastByte   = 2'd3;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    PhType      = 4'd0,
    PhOuterLen  = 4'd1,
    PhFirstTag  = 4'd2,
    PhNextTag   = 4'd3,
    PhStrLen    = 4'd4,
    PhStrData   = 4'd5,
    PhPackLen   = 4'd6,
    PhPackFloat = 4'd7,
    PhPackInt   = 4'd8,
    PhUnpFloat  = 4'd9,
    PhUnpInt    = 4'd10,
    PhDone      = 4'd11,
    PhError     = 4'd12
  } phase_e;

  typedef struct packed {
    logic is_delim;    // 0x0A: bytes list type, or delimited field tag
    logic is_float;    // 0x12
    logic is_int64;    // 0x1A
    logic is_fixed32;  // 0x0D
    logic is_varint;   // 0x08
    logic cont;        // varint continuation bit
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic        last;
    byte_class_t cls;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        element_end;
    logic        value_valid;
    logic [1:0]  list_type;
  } result_user_t;

endpackage

`default_nettype wire

// File: rtl/flwd_front.sv
// Input side: stream handshake and byte classification.
// Depends on flwd_pkg; feeds flwd_queue.
`timescale 1ns / 1ps
`default_nettype none

module flwd_front (
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            byte_valid_i,
  input  wire logic            msg_last_i,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output flwd_pkg::entry_t     push_entry_o
);
  import flwd_pkg::*;

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

  always_comb begin
    push_entry_o                = '0;
    push_entry_o.data           = data_byte_i;
    push_entry_o.byte_valid     = byte_valid_i;
    push_entry_o.last           = msg_last_i;
    push_entry_o.cls.is_delim   = (data_byte_i == TagDelimited);
    push_entry_o.cls.is_float   = (data_byte_i == TagFloatList);
    push_entry_o.cls.is_int64   = (data_byte_i == TagInt64List);
    push_entry_o.cls.is_fixed32 = (data_byte_i == TagFixed32);
    push_entry_o.cls.is_varint  = (data_byte_i == TagVarint);
    push_entry_o.cls.cont       = data_byte_i[7];
  end

endmodule

`default_nettype wire

// File: rtl/flwd_queue.sv
// Short register queue of classified words between front and back.
// Depends on flwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flwd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire flwd_pkg::entry_t push_entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output flwd_pkg::entry_t     head_o
);
  import flwd_pkg::*;

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/flwd_back.sv
// Parser state machine and output register; consumes one queued word per cycle
// unless the output stalls. Depends on flwd_pkg; fed by flwd_queue.
`timescale 1ns / 1ps
`default_nettype none

module flwd_back #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire flwd_pkg::entry_t q_head_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [63:0]          element_value_o,
  output flwd_pkg::result_user_t m_user_o,
  output logic                 done_res_o
);
  import flwd_pkg::*;

  localparam logic [31:0] LenMax = 32'((64'(1) << LENGTH_BITS) - 64'(1));

  phase_e                 phase_q, phase_d;
  logic [1:0]             kind_q, kind_d;
  logic [LENGTH_BITS-1:0] outer_q, outer_d;
  logic [LENGTH_BITS-1:0] inner_q, inner_d;
  logic [63:0]            acc_q, acc_d;
  logic [3:0]             vcnt_q, vcnt_d;
  logic [1:0]             wcnt_q, wcnt_d;
  logic [1:0]             err_q, err_d;

  logic                   out_valid_q, out_valid_d;
  logic [63:0]            out_value_q;
  result_user_t           out_user_q;
  logic                   out_last_q;

  // varint and word accumulation for the current byte
  logic [63:0]            vf_acc;
  logic [3:0]             vf_cnt;
  logic                   vf_complete, vf_over;
  logic [31:0]            len_sat;
  logic [LENGTH_BITS-1:0] len_val;
  logic [63:0]            wf_acc;
  logic                   wf_done;

  logic                   emit, vv, ee, res;
  logic [63:0]            val;
  logic [1:0]             st;
  logic                   pkt_last;
  logic [7:0]             b;

  assign b        = q_head_i.data;
  assign pkt_last = q_head_i.last;
  assign pop_o    = q_valid_i && (!out_valid_q || m_ready_i);

  always_comb begin
    vf_acc = acc_q;
    vf_cnt = vcnt_q;
    if (vcnt_q < VarintMaxBytes) begin
      for (int k = 0; k < 10; k++) begin
        if (vcnt_q == 4'(k)) begin
          vf_acc = acc_q | (64'(b[6:0]) << (7 * k));
        end
      end
      vf_cnt = vcnt_q + 4'd1;
    end
    vf_complete = !q_head_i.cls.cont;
    vf_over     = q_head_i.cls.cont && (vf_cnt >= VarintMaxBytes);
    len_sat     = (vf_acc[31:0] > LenMax) ? LenMax : vf_acc[31:0];
    len_val     = LENGTH_BITS'(len_sat);
    wf_acc      = acc_q | (64'(b) << {wcnt_q, 3'b000});
    wf_done     = (wcnt_q == WordLastByte);
  end

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    outer_d = outer_q;
    inner_d = inner_q;
    acc_d   = acc_q;
    vcnt_d  = vcnt_q;
    wcnt_d  = wcnt_q;
    err_d   = err_q;
    emit    = 1'b0;
    vv      = 1'b0;
    ee      = 1'b0;
    val     = '0;

    if (pop_o && q_head_i.byte_valid) begin
      unique case (phase_q)
        PhType: begin
          if (q_head_i.cls.is_delim) begin
            kind_d = KindBytes;
          end else if (q_head_i.cls.is_float) begin
            kind_d = KindFloat;
          end else if (q_head_i.cls.is_int64) begin
            kind_d = KindInt64;
          end else begin
            kind_d = KindInvalid;
          end
          if (kind_d == KindInvalid) begin
            err_d   = StatusUnsupported;
            phase_d = PhError;
          end else begin
            acc_d   = '0;
            vcnt_d  = '0;
            wcnt_d  = '0;
            phase_d = PhOuterLen;
          end
        end
        PhOuterLen: begin
          acc_d  = vf_acc;
          vcnt_d = vf_cnt;
          if (vf_over) begin
            err_d   = StatusParseError;
            phase_d = PhError;
          end else if (vf_complete) begin
            outer_d = len_val;
            acc_d   = '0;
            vcnt_d  = '0;
            wcnt_d  = '0;
            phase_d = (len_val != '0) ? PhFirstTag : PhNextTag;
            if (len_val == '0) begin
              phase_d = PhDone;
            end
          end
        end
        PhFirstTag, PhNextTag, PhStrLen, PhStrData, PhPackLen,
        PhPackFloat, PhPackInt, PhUnpFloat, PhUnpInt: begin
          outer_d = outer_q - 1'b1;
          case (phase_q)
            PhFirstTag, PhNextTag: begin
              acc_d  = '0;
              vcnt_d = '0;
              wcnt_d = '0;
              if (kind_q == KindBytes) begin
                if (q_head_i.cls.is_delim) begin
                  phase_d = PhStrLen;
                end else begin
                  err_d   = StatusParseError;
                  phase_d = PhError;
                end
              end else if (q_head_i.cls.is_delim && phase_q == PhFirstTag) begin
                phase_d = PhPackLen;
              end else if (kind_q == KindFloat && q_head_i.cls.is_fixed32) begin
                phase_d = PhUnpFloat;
              end else if (kind_q == KindInt64 && q_head_i.cls.is_varint) begin
                phase_d = PhUnpInt;
              end else begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end
            end
            PhStrLen: begin
              acc_d  = vf_acc;
              vcnt_d = vf_cnt;
              if (vf_over) begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end else if (vf_complete) begin
                if (len_val > outer_d) begin
                  err_d   = StatusParseError;
                  phase_d = PhError;
                end else if (len_val == '0) begin
                  emit    = 1'b1;
                  ee      = 1'b1;
                  acc_d   = '0;
                  vcnt_d  = '0;
                  wcnt_d  = '0;
                  phase_d = (outer_d == '0) ? PhDone : PhNextTag;
                end else begin
                  inner_d = len_val;
                  phase_d = PhStrData;
                end
              end
            end
            PhStrData: begin
              inner_d = inner_q - 1'b1;
              emit    = 1'b1;
              vv      = 1'b1;
              val     = 64'(b);
              if (inner_d == '0) begin
                ee      = 1'b1;
                acc_d   = '0;
                vcnt_d  = '0;
                wcnt_d  = '0;
                phase_d = (outer_d == '0) ? PhDone : PhNextTag;
              end
            end
            PhPackLen: begin
              acc_d  = vf_acc;
              vcnt_d = vf_cnt;
              if (vf_over) begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end else if (vf_complete) begin
                inner_d = (len_val < outer_d) ? len_val : outer_d;
                acc_d   = '0;
                vcnt_d  = '0;
                wcnt_d  = '0;
                if (inner_d == '0) begin
                  phase_d = PhDone;
                end else begin
                  phase_d = (kind_q == KindFloat) ? PhPackFloat : PhPackInt;
                end
              end
            end
            PhPackFloat: begin
              inner_d = inner_q - 1'b1;
              acc_d   = wf_acc;
              if (wf_done) begin
                emit   = 1'b1;
                vv     = 1'b1;
                ee     = 1'b1;
                val    = wf_acc;
                acc_d  = '0;
                vcnt_d = '0;
                wcnt_d = '0;
                if (inner_d == '0) begin
                  phase_d = PhDone;
                end
              end else begin
                wcnt_d = wcnt_q + 2'd1;
                if (inner_d == '0) begin
                  err_d   = StatusParseError;
                  phase_d = PhError;
                end
              end
            end
            PhPackInt: begin
              inner_d = inner_q - 1'b1;
              acc_d   = vf_acc;
              vcnt_d  = vf_cnt;
              if (vf_over) begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end else if (vf_complete) begin
                emit   = 1'b1;
                vv     = 1'b1;
                ee     = 1'b1;
                val    = vf_acc;
                acc_d  = '0;
                vcnt_d = '0;
                wcnt_d = '0;
                if (inner_d == '0) begin
                  phase_d = PhDone;
                end
              end else if (inner_d == '0) begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end
            end
            PhUnpFloat: begin
              acc_d = wf_acc;
              if (wf_done) begin
                emit    = 1'b1;
                vv      = 1'b1;
                ee      = 1'b1;
                val     = wf_acc;
                acc_d   = '0;
                vcnt_d  = '0;
                wcnt_d  = '0;
                phase_d = (outer_d == '0) ? PhDone : PhNextTag;
              end else begin
                wcnt_d = wcnt_q + 2'd1;
              end
            end
            default: begin
              acc_d  = vf_acc;
              vcnt_d = vf_cnt;
              if (vf_over) begin
                err_d   = StatusParseError;
                phase_d = PhError;
              end else if (vf_complete) begin
                emit    = 1'b1;
                vv      = 1'b1;
                ee      = 1'b1;
                val     = vf_acc;
                acc_d   = '0;
                vcnt_d  = '0;
                wcnt_d  = '0;
                phase_d = (outer_d == '0) ? PhDone : PhNextTag;
              end
            end
          endcase
          // element cut off by the outer limit
          if (phase_d inside {PhStrLen, PhStrData, PhPackLen, PhPackFloat,
                              PhPackInt, PhUnpFloat, PhUnpInt} && outer_d == '0) begin
            err_d   = StatusParseError;
            phase_d = PhError;
          end
        end
        default: begin
        end
      endcase
    end

    res = pop_o && (emit || pkt_last);
    st  = err_d;
    if (pkt_last && err_d == StatusOk && phase_d != PhDone && phase_d != PhType) begin
      st = StatusParseError;
    end
  end

  assign out_valid_d = res ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhType;
      kind_q      <= KindInvalid;
      outer_q     <= '0;
      inner_q     <= '0;
      acc_q       <= '0;
      vcnt_q      <= '0;
      wcnt_q      <= '0;
      err_q       <= StatusOk;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o && pkt_last) begin
        phase_q <= PhType;
        kind_q  <= KindInvalid;
        outer_q <= '0;
        inner_q <= '0;
        acc_q   <= '0;
        vcnt_q  <= '0;
        wcnt_q  <= '0;
        err_q   <= StatusOk;
      end else begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        outer_q <= outer_d;
        inner_q <= inner_d;
        acc_q   <= acc_d;
        vcnt_q  <= vcnt_d;
        wcnt_q  <= wcnt_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res) begin
      out_value_q            <= vv ? val : '0;
      out_user_q.list_type   <= kind_d;
      out_user_q.value_valid <= vv;
      out_user_q.element_end <= ee;
      out_user_q.status      <= st;
      out_last_q             <= pkt_last;
    end
  end

  assign m_valid_o       = out_valid_q;
  assign element_value_o = out_value_q;
  assign m_user_o        = out_user_q;
  assign done_res_o      = out_last_q;

endmodule

`default_nettype wire

// File: rtl/feature_list_wire_decoder_unit.sv
// Top level of the feature list wire decoder: front, word queue, parser back end.
// Depends on flwd_pkg, flwd_front, flwd_queue, flwd_back.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one serialized feature list message fed one byte per input word and
// emits one output word per string byte, empty string or completed number, plus
// a status word on the message's last input word (tlast). Sustained rate is one
// input word per clock; an input word is written into the queue when it is
// accepted, and its output word is loaded into the output register when the back
// end pops it from the queue. The rate is set by the parser update in the back
// end, which handles one varint byte or fixed32 byte per cycle.
// The input stalls only while the two-entry queue is full, which happens when
// the output word is held off by tready.
// Input tuser is byte_valid; a word with tuser low carries no byte.
module feature_list_wire_decoder_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_valid
  input  wire logic        s_axis_tlast,   // msg_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] element_value
  output logic [5:0]       m_axis_tuser,   // [1:0] list_type, [2] value_valid,
                                           // [3] element_end, [5:4] status
  output logic             m_axis_tlast    // done_res
);
  import flwd_pkg::*;

  logic         push, q_full, pop, q_valid;
  entry_t       push_entry, q_head;
  result_user_t out_user;

  flwd_front u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .byte_valid_i (s_axis_tuser),
    .msg_last_i   (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  flwd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (q_head)
  );

  flwd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .pop_o           (pop),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .element_value_o (m_axis_tdata),
    .m_user_o        (out_user),
    .done_res_o      (m_axis_tlast)
  );

  assign m_axis_tuser = out_user;

endmodule

`default_nettype wire

// File: bench/flwd_decode_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the feature list wire decoder: tracks the parser state from the
// accepted input words, predicts each output word and compares it field by field.
// Depends on flwd_pkg.
module flwd_decode_checker
  import flwd_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [5:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors_o,
  output int          pending_o
);

  typedef enum logic [1:0] {VarMore, VarDone, VarOverlong} varint_e;

  typedef struct packed {
    result_user_t user;
    logic [63:0]  value;
    logic         done;
  } decoded_t;

  phase_e      ph;
  logic [1:0]  kind;
  logic [31:0] outer_rem;
  logic [31:0] inner_rem;
  logic [63:0] acc;
  logic [3:0]  vcount;
  logic [1:0]  wcount;
  logic [1:0]  err;
  decoded_t    pending_results[$];

  function automatic logic [31:0] length_of(logic [63:0] a);
    logic [31:0] cap;
    cap = 32'((64'd1 << LENGTH_BITS) - 64'd1);
    return (a[31:0] > cap) ? cap : a[31:0];
  endfunction

  task automatic clear_acc();
    acc = '0;
    vcount = '0;
    wcount = '0;
  endtask

  task automatic restart();
    ph = PhType;
    kind = KindInvalid;
    outer_rem = '0;
    inner_rem = '0;
    err = StatusOk;
    clear_acc();
  endtask

  task automatic set_error(input logic [1:0] code);
    err = code;
    ph = PhError;
  endtask

  task automatic close_element();
    clear_acc();
    if (outer_rem == 0) ph = PhDone;
    else ph = PhNextTag;
  endtask

  task automatic feed_varint(input logic [7:0] b, output varint_e r);
    if (vcount < VarintMaxBytes) begin
      acc = acc | (64'(b[6:0]) << (7 * vcount));
      vcount = vcount + 4'd1;
    end
    if (!b[7]) r = VarDone;
    else if (vcount >= VarintMaxBytes) r = VarOverlong;
    else r = VarMore;
  endtask

  task automatic feed_word(input logic [7:0] b, output logic full);
    acc = acc | (64'(b) << (8 * wcount));
    full = (wcount == WordLastByte);
    if (!full) wcount = wcount + 2'd1;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors_o++;
  endtask

  task automatic decode_word(input logic [7:0] b, input logic bv, input logic last);
    logic        emit, vv, ee, full;
    logic [63:0] val;
    logic [31:0] n;
    logic [1:0]  st;
    varint_e     r;
    decoded_t    res;
    emit = 1'b0;
    vv = 1'b0;
    ee = 1'b0;
    val = '0;
    if (bv) begin
      case (ph)
        PhType: begin
          if (b == TagBytesList) kind = KindBytes;
          else if (b == TagFloatList) kind = KindFloat;
          else if (b == TagInt64List) kind = KindInt64;
          else kind = KindInvalid;
          if (kind == KindInvalid) begin
            set_error(StatusUnsupported);
          end else begin
            clear_acc();
            ph = PhOuterLen;
          end
        end
        PhOuterLen: begin
          feed_varint(b, r);
          if (r == VarOverlong) begin
            set_error(StatusParseError);
          end else if (r == VarDone) begin
            outer_rem = length_of(acc);
            clear_acc();
            if (outer_rem != 0) ph = PhFirstTag;
            else ph = PhDone;
          end
        end
        PhDone, PhError: ;
        default: begin
          outer_rem = outer_rem - 32'd1;
          case (ph)
            PhFirstTag, PhNextTag: begin
              clear_acc();
              if (kind == KindBytes) begin
                if (b == TagDelimited) ph = PhStrLen;
                else set_error(StatusParseError);
              end else if (b == TagDelimited && ph == PhFirstTag) begin
                ph = PhPackLen;
              end else if (kind == KindFloat && b == TagFixed32) begin
                ph = PhUnpFloat;
              end else if (kind == KindInt64 && b == TagVarint) begin
                ph = PhUnpInt;
              end else begin
                set_error(StatusParseError);
              end
            end
            PhStrLen: begin
              feed_varint(b, r);
              if (r == VarOverlong) begin
                set_error(StatusParseError);
              end else if (r == VarDone) begin
                n = length_of(acc);
                if (n > outer_rem) begin
                  set_error(StatusParseError);
                end else if (n == 0) begin
                  emit = 1'b1;
                  ee = 1'b1;
                  close_element();
                end else begin
                  inner_rem = n;
                  ph = PhStrData;
                end
              end
            end
            PhStrData: begin
              inner_rem = inner_rem - 32'd1;
              emit = 1'b1;
              vv = 1'b1;
              val = 64'(b);
              if (inner_rem == 0) begin
                ee = 1'b1;
                close_element();
              end
            end
            PhPackLen: begin
              feed_varint(b, r);
              if (r == VarOverlong) begin
                set_error(StatusParseError);
              end else if (r == VarDone) begin
                n = length_of(acc);
                inner_rem = (n < outer_rem) ? n : outer_rem;
                clear_acc();
                if (inner_rem == 0) ph = PhDone;
                else if (kind == KindFloat) ph = PhPackFloat;
                else ph = PhPackInt;
              end
            end
            PhPackFloat: begin
              inner_rem = inner_rem - 32'd1;
              feed_word(b, full);
              if (full) begin
                emit = 1'b1;
                vv = 1'b1;
                ee = 1'b1;
                val = acc;
                clear_acc();
                if (inner_rem == 0) ph = PhDone;
              end else if (inner_rem == 0) begin
                set_error(StatusParseError);
              end
            end
            PhPackInt: begin
              inner_rem = inner_rem - 32'd1;
              feed_varint(b, r);
              if (r == VarOverlong) begin
                set_error(StatusParseError);
              end else if (r == VarDone) begin
                emit = 1'b1;
                vv = 1'b1;
                ee = 1'b1;
                val = acc;
                clear_acc();
                if (inner_rem == 0) ph = PhDone;
              end else if (inner_rem == 0) begin
                set_error(StatusParseError);
              end
            end
            PhUnpFloat: begin
              feed_word(b, full);
              if (full) begin
                emit = 1'b1;
                vv = 1'b1;
                ee = 1'b1;
                val = acc;
                close_element();
              end
            end
            default: begin
              feed_varint(b, r);
              if (r == VarOverlong) begin
                set_error(StatusParseError);
              end else if (r == VarDone) begin
                emit = 1'b1;
                vv = 1'b1;
                ee = 1'b1;
                val = acc;
                close_element();
              end
            end
          endcase
          if (ph >= PhStrLen && ph <= PhUnpInt && outer_rem == 0)
            set_error(StatusParseError);
        end
      endcase
    end

    if (emit || last) begin
      st = err;
      // message cut short before the list closed
      if (last && st == StatusOk && ph != PhDone && ph != PhType) st = StatusParseError;
      res.user.list_type = kind;
      res.user.value_valid = vv;
      res.user.element_end = ee;
      res.user.status = st;
      res.value = vv ? val : 64'd0;
      res.done = last;
      pending_results = {pending_results, res};
    end
    if (last) restart();
  endtask

  always @(posedge clk_i) begin
    decoded_t     want;
    result_user_t got;
    if (!rst_ni) begin
      restart();
      pending_results.delete();
      errors_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        decode_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("word with nothing expected", m_axis_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          got = m_axis_tuser;
          if (got.list_type !== want.user.list_type)
            report_mismatch("list_type", 64'(got.list_type), 64'(want.user.list_type));
          if (got.value_valid !== want.user.value_valid)
            report_mismatch("value_valid", 64'(got.value_valid), 64'(want.user.value_valid));
          if (got.element_end !== want.user.element_end)
            report_mismatch("element_end", 64'(got.element_end), 64'(want.user.element_end));
          if (got.status !== want.user.status)
            report_mismatch("status", 64'(got.status), 64'(want.user.status));
          if (m_axis_tdata !== want.value)
            report_mismatch("element_value", m_axis_tdata, want.value);
          if (m_axis_tlast !== want.done)
            report_mismatch("done", 64'(m_axis_tlast), 64'(want.done));
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

// File: bench/feature_list_wire_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for feature_list_wire_decoder_unit: drives serialized feature
// messages (directed, then random well-formed and damaged ones) with random
// stalls on both sides. Depends on flwd_pkg, flwd_decode_checker and the RTL.
module feature_list_wire_decoder_unit_tb;
  import flwd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int NumItems   = 650;
  localparam int IdleLimit  = 2000;
  localparam int HoldCycles = 80;
  localparam int TailCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int      errors;
  int      pending;
  int      idle_cycles;
  int      items_sent;
  bit      quiet;
  bit      hold_req;
  byte_q_t body;
  byte_q_t frame;

  feature_list_wire_decoder_unit #(
    .LENGTH_BITS(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  flwd_decode_checker #(
    .LENGTH_BITS(32)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    m_axis_tready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  function automatic byte_q_t varint_bytes(logic [63:0] v, int pad);
    byte_q_t q;
    do begin
      q = {q, {v[63:7] != 57'd0, v[6:0]}};
      v = v >> 7;
    end while (v != 0);
    if (pad > 10 - q.size()) pad = 10 - q.size();
    if (pad > 0) begin
      // non-minimal encoding: zero groups after the value
      q[q.size() - 1] = q[q.size() - 1] | 8'h80;
      repeat (pad - 1) q = {q, 8'h80};
      q = {q, 8'h00};
    end
    return q;
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [63:0] rand_i64();
    case ($urandom_range(5))
      0: return 64'($urandom_range(127));
      1: return 64'($urandom_range(16383));
      2: return {$urandom, $urandom};
      3: return '1;
      4: return 64'h8000_0000_0000_0000;
      default: return 64'($urandom);
    endcase
  endfunction

  task automatic put_word(input logic [7:0] b, input logic bv, input logic last);
    while (!quiet && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= bv;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (bv || last) items_sent++;
  endtask

  task automatic send_frame(input bit plain);
    bit noisy;
    bit split_end;
    noisy = !plain && $urandom_range(9) == 0;
    split_end = !plain && $urandom_range(7) == 0;
    if (frame.size() == 0) begin
      put_word(8'($urandom), 1'b0, 1'b1);
    end else begin
      foreach (frame[i]) begin
        if (noisy && $urandom_range(3) == 0) put_word(8'($urandom), 1'b0, 1'b0);
        put_word(frame[i], 1'b1, !split_end && i == frame.size() - 1);
      end
      if (split_end) put_word(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic build_random_frame();
    logic [1:0]  kind;
    logic [7:0]  type_tag;
    logic [63:0] lv;
    bit          unpacked_form;
    int          n;
    int          len;
    int          mode;
    int          outer;
    byte_q_t     elems;
    body = {};
    frame = {};
    elems = {};
    kind = 2'($urandom_range(KindBytes, KindInt64));
    unpacked_form = 1'($urandom_range(1));
    n = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
    mode = $urandom_range(99);
    case (kind)
      KindBytes: begin
        type_tag = TagBytesList;
        for (int i = 0; i < n; i++) begin
          len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          body = {body, TagDelimited};
          body = {body, varint_bytes(64'(len), pick_pad())};
          repeat (len) body = {body, 8'($urandom)};
        end
      end
      KindFloat: begin
        type_tag = TagFloatList;
        for (int i = 0; i < n; i++) begin
          if (unpacked_form) elems = {elems, TagFixed32};
          repeat (4) elems = {elems, 8'($urandom)};
        end
      end
      default: begin
        type_tag = TagInt64List;
        for (int i = 0; i < n; i++) begin
          if (unpacked_form) elems = {elems, TagVarint};
          elems = {elems, varint_bytes(rand_i64(), pick_pad())};
        end
      end
    endcase
    if (kind != KindBytes) begin
      if (unpacked_form) begin
        body = elems;
      end else begin
        // a packed length past the outer body gets clipped
        len = elems.size() + ((mode >= 96) ? $urandom_range(1, 20) : 0);
        body = {body, TagDelimited};
        body = {body, varint_bytes(64'(len), pick_pad()), elems};
      end
    end
    if (mode >= 86 && mode < 90) begin
      body = {};
      body = {body, (kind == KindInt64) ? TagVarint : TagDelimited};
      repeat ($urandom_range(10, 12)) body = {body, 8'h80 | 8'($urandom)};
    end
    outer = body.size();
    if (mode >= 82 && mode < 86) begin
      if ($urandom_range(1)) outer = outer + $urandom_range(1, 3);
      else outer = outer - $urandom_range(1, 3);
      if (outer < 0) outer = 0;
    end

    frame = {frame, type_tag};
    if (mode >= 86 && mode < 90 && $urandom_range(1)) begin
      repeat ($urandom_range(10, 12)) frame = {frame, 8'h80 | 8'($urandom)};
    end else begin
      lv = 64'(outer);
      // upper length bits are dropped by the block
      if ($urandom_range(9) == 0) lv[63:32] = $urandom;
      frame = {frame, varint_bytes(lv, pick_pad()), body};
    end

    if (mode >= 62 && mode < 70) begin
      repeat ($urandom_range(1, 4)) if (frame.size() > 1) void'(frame.pop_back());
    end else if (mode >= 70 && mode < 76) begin
      frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
    end else if (mode >= 76 && mode < 82) begin
      repeat ($urandom_range(1, 4)) frame = {frame, 8'($urandom)};
    end else if (mode >= 90 && mode < 96) begin
      frame = {};
      repeat ($urandom_range(0, 12)) frame = {frame, 8'($urandom)};
    end
  endtask

  initial begin
    int msg_idx;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    frame = {};
    send_frame(1'b1);
    frame = {8'hFF};
    send_frame(1'b1);
    frame = {TagBytesList, 8'd5, TagDelimited, 8'd0, TagDelimited, 8'd1, 8'hAB};
    send_frame(1'b1);
    frame = {TagInt64List, 8'd0};
    send_frame(1'b1);
    frame = {TagFloatList, 8'd6, TagDelimited, 8'd4, 8'h00, 8'h00, 8'h80, 8'h7F};
    send_frame(1'b1);
    frame = {TagInt64List, 8'd3, TagVarint, 8'h96};
    send_frame(1'b1);
    wait_drained();

    items_sent = 0;
    msg_idx = 0;
    while (items_sent < NumItems) begin
      if (msg_idx == 10) hold_req = 1'b1;
      if (msg_idx == 20) wait_drained();
      quiet = msg_idx >= 28 && msg_idx < 36;
      build_random_frame();
      send_frame(1'b0);
      msg_idx++;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/flwd_pkg.sv
rtl/flwd_front.sv
rtl/flwd_queue.sv
rtl/flwd_back.sv
rtl/feature_list_wire_decoder_unit.sv
bench/flwd_decode_checker.sv
bench/feature_list_wire_decoder_unit_tb.sv
